### src/assert_macros.svh
// assertion macros included by rtls_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside of reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/rtls_pkg.sv
// types and constants of the radio transmit link supervisor
`default_nettype none

package rtls_pkg;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_WRITE     = 3'd1,
      CMD_CLR_SENT  = 3'd2,
      CMD_CLR_MAXRT = 3'd3,
      CMD_FLUSH_TX  = 3'd4,
      CMD_FLUSH_RX  = 3'd5
   } cmd_type;

   localparam int MAX_CMDS    = 7;
   localparam int CMD_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam int ST_SENT_BIT   = 5;
   localparam int ST_MAXRT_BIT  = 4;
   localparam int ST_TXFULL_BIT = 0;
   localparam int FS_TXFULL_BIT = 5;
   localparam int FS_RXFULL_BIT = 1;

   localparam logic [7:0] LIMIT_RESET = 8'd20;

   localparam logic REG_SILENCE_LIMIT = 1'b0;
   localparam logic REG_RETRY_LIMIT   = 1'b1;

   typedef struct packed {
      logic [7:0] silence_limit;
      logic [7:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      cmd_type cmd;
      logic    link_up;
      logic    led_state;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_CMDS-1:0] ents;
      logic [CMD_IDX_W-1:0]     last_idx;
   } record_type;

endpackage

`default_nettype wire

### src/rtls_front.sv
// front end: accepts polls, runs the link state machine, builds the command list
`default_nettype none

module rtls_front
   import rtls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       poll_valid,
   input  wire logic [7:0] status_first,
   input  wire logic [7:0] queue_status,
   input  wire logic [7:0] status_second,
   input  wire logic       queue_ready,
   output logic            push,
   output record_type      push_rec
);

   logic       link_lost_ff, link_lost_in;
   logic       pending_ff, pending_in;
   logic [7:0] silence_ff, silence_in;
   logic [7:0] retry_ff, retry_in;
   logic       led_ff, led_in;

   assign push = poll_valid && queue_ready;

   always_comb begin
      logic [CMD_IDX_W-1:0] n;
      logic                 done;
      logic [8:0]           cnt;
      link_lost_in = link_lost_ff;
      pending_in   = pending_ff;
      silence_in   = silence_ff;
      retry_in     = retry_ff;
      led_in       = led_ff;
      n            = '0;
      done         = 1'b0;
      cnt          = '0;
      push_rec     = '0;

      if (link_lost_in) begin
         if (!queue_status[FS_TXFULL_BIT]) begin
            push_rec.ents[n] = '{CMD_WRITE, !link_lost_in, led_in};
            n = n + 3'd1;
         end
         if (status_first[ST_SENT_BIT]) begin
            led_in       = 1'b1;
            link_lost_in = 1'b0;
            push_rec.ents[n] = '{CMD_CLR_SENT, !link_lost_in, led_in};
            n = n + 3'd1;
         end
         if (status_first[ST_TXFULL_BIT]) begin
            push_rec.ents[n] = '{CMD_FLUSH_TX, !link_lost_in, led_in};
            n = n + 3'd1;
         end
         if (queue_status[FS_RXFULL_BIT]) begin
            push_rec.ents[n] = '{CMD_FLUSH_RX, !link_lost_in, led_in};
            n = n + 3'd1;
         end
         if (status_first[ST_MAXRT_BIT]) begin
            push_rec.ents[n] = '{CMD_CLR_MAXRT, !link_lost_in, led_in};
            n = n + 3'd1;
         end
      end

      if (!link_lost_in) begin
         if (status_second[ST_SENT_BIT] && pending_in) begin
            led_in     = 1'b1;
            pending_in = 1'b0;
            push_rec.ents[n] = '{CMD_CLR_SENT, !link_lost_in, led_in};
            n = n + 3'd1;
         end
         if (!status_second[ST_TXFULL_BIT] && !pending_in) begin
            pending_in = 1'b1;
            push_rec.ents[n] = '{CMD_WRITE, !link_lost_in, led_in};
            n = n + 3'd1;
            done = 1'b1;
         end
         if (!done) begin
            if (!status_second[ST_MAXRT_BIT] && !status_second[ST_TXFULL_BIT]
                && pending_in) begin
               cnt = {1'b0, silence_ff} + 9'd1;
               if (cnt > {1'b0, cfg.silence_limit}) begin
                  silence_in   = '0;
                  pending_in   = 1'b0;
                  link_lost_in = 1'b1;
                  led_in       = 1'b0;
               end else begin
                  silence_in = cnt[7:0];
               end
            end
            if (status_second[ST_MAXRT_BIT]) begin
               led_in = 1'b0;
               if (retry_ff < cfg.retry_limit) begin
                  retry_in = retry_ff + 8'd1;
                  push_rec.ents[n] = '{CMD_CLR_MAXRT, !link_lost_in, led_in};
                  n = n + 3'd1;
               end else begin
                  retry_in     = '0;
                  link_lost_in = 1'b1;
                  push_rec.ents[n] = '{CMD_FLUSH_TX, !link_lost_in, led_in};
                  n = n + 3'd1;
               end
            end
         end
      end

      if (n == '0) begin
         push_rec.ents[0]  = '{CMD_NONE, !link_lost_in, led_in};
         push_rec.last_idx = '0;
      end else begin
         push_rec.last_idx = n - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_lost_ff <= 1'b1;
         pending_ff   <= 1'b0;
         silence_ff   <= '0;
         retry_ff     <= '0;
         led_ff       <= 1'b0;
      end else if (push) begin
         link_lost_ff <= link_lost_in;
         pending_ff   <= pending_in;
         silence_ff   <= silence_in;
         retry_ff     <= retry_in;
         led_ff       <= led_in;
      end
   end

endmodule

`default_nettype wire

### src/rtls_queue.sv
// short queue of command lists between front and back end
`default_nettype none

module rtls_queue
   import rtls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire record_type push_rec,
   output logic            ready,
   input  wire logic       pop,
   output logic            head_valid,
   output record_type      head_rec
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   record_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;

   assign ready      = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### src/rtls_back.sv
// back end: plays one command list per poll onto the result channel
`default_nettype none

module rtls_back
   import rtls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire record_type head_rec,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output entry_type       out_ent,
   output logic            out_last
);

   logic                 valid_ff;
   logic [CMD_IDX_W-1:0] idx_ff;
   entry_type            ent_ff;
   logic                 last_ff;
   logic                 load;
   logic                 is_last;

   assign load      = !valid_ff || out_ready;
   assign is_last   = (idx_ff == head_rec.last_idx);
   assign pop       = load && head_valid && is_last;
   assign out_valid = valid_ff;
   assign out_ent   = ent_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= head_valid;
         if (head_valid) begin
            idx_ff <= is_last ? '0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         ent_ff  <= head_rec.ents[idx_ff];
         last_ff <= is_last;
      end
   end

endmodule

`default_nettype wire

### src/radio_tx_link_supervisor.sv
// A poll's first command is written into the queue, then into the output register.
// Throughput: one command per cycle while rsp_tready holds; a poll has 1 to 7 commands,
// the front end takes a poll per cycle while the 2-entry queue has room.
// Reset: link marked lost, counters and pending flag cleared, both limits 20,
// queue and output register emptied.
`default_nettype none

module radio_tx_link_supervisor
   import rtls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // status_first, queue_status, status_second
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // command[2:0], link_up, led_state, zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg_ff;
   logic       cfg_wr;
   logic       push;
   record_type push_rec;
   logic       q_ready;
   logic       pop;
   logic       head_valid;
   record_type head_rec;
   entry_type  out_ent;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.silence_limit <= LIMIT_RESET;
         cfg_ff.retry_limit   <= LIMIT_RESET;
      end else if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_SILENCE_LIMIT: cfg_ff.silence_limit <= csr_pwdata[7:0];
            REG_RETRY_LIMIT:   cfg_ff.retry_limit   <= csr_pwdata[7:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SILENCE_LIMIT: csr_prdata = {24'd0, cfg_ff.silence_limit};
         REG_RETRY_LIMIT:   csr_prdata = {24'd0, cfg_ff.retry_limit};
         default:           csr_prdata = '0;
      endcase
   end

   assign req_tready = q_ready;

   rtls_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .poll_valid    (req_tvalid),
      .status_first  (req_tdata[7:0]),
      .queue_status  (req_tdata[15:8]),
      .status_second (req_tdata[23:16]),
      .queue_ready   (q_ready),
      .push          (push),
      .push_rec      (push_rec)
   );

   rtls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .ready      (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   rtls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_ent    (out_ent),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, out_ent.led_state, out_ent.link_up, out_ent.cmd};

endmodule

`default_nettype wire

### src/rtls_checker.sv
// port-level checks of the radio transmit link supervisor
`default_nettype none
`include "assert_macros.svh"

module rtls_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_pready
);

   `ASSERT_CLK(a_cmd_code, clock, reset, rsp_tvalid |-> (rsp_tdata[2:0] <= 3'd5), "bad command code")
   `ASSERT_CLK(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[7:5] == 3'd0), "pad bits set")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "stalled transaction changed")
   `ASSERT_ALWAYS(a_pready, clock, csr_pready, "csr_pready low")

endmodule

bind radio_tx_link_supervisor rtls_checker u_rtls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

`default_nettype wire

### tb/link_supervisor_checker.sv
// checker for the radio transmit link supervisor: predicts commands per poll and compares
`timescale 1ns / 100ps

module link_supervisor_checker
   import rtls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      cmd_type cmd;
      logic    link_up;
      logic    led_state;
      logic    last;
   } bus_cmd_type;

   logic [7:0] quiet_limit;
   logic [7:0] retry_cap;

   logic       link_down;
   logic       tx_outstanding;
   logic [7:0] quiet_polls;
   logic [7:0] retry_events;
   logic       led_on;

   bus_cmd_type poll_cmds[MAX_CMDS];
   int          poll_len;
   bus_cmd_type cmd_queue[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic add_cmd(input cmd_type cmd);
      poll_cmds[poll_len] = '{cmd: cmd, link_up: !link_down, led_state: led_on, last: 1'b0};
      poll_len++;
   endtask

   task automatic supervise_poll(input logic [7:0] st1, input logic [7:0] fifo,
                                 input logic [7:0] st2);
      logic       written;
      logic [8:0] quiet_next;
      written  = 1'b0;
      poll_len = 0;
      if (link_down) begin
         if (!fifo[FS_TXFULL_BIT]) add_cmd(CMD_WRITE);
         if (st1[ST_SENT_BIT]) begin
            led_on    = 1'b1;
            link_down = 1'b0;
            add_cmd(CMD_CLR_SENT);
         end
         if (st1[ST_TXFULL_BIT]) add_cmd(CMD_FLUSH_TX);
         if (fifo[FS_RXFULL_BIT]) add_cmd(CMD_FLUSH_RX);
         if (st1[ST_MAXRT_BIT]) add_cmd(CMD_CLR_MAXRT);
      end
      if (!link_down) begin
         if (st2[ST_SENT_BIT] && tx_outstanding) begin
            led_on         = 1'b1;
            tx_outstanding = 1'b0;
            add_cmd(CMD_CLR_SENT);
         end
         if (!st2[ST_TXFULL_BIT] && !tx_outstanding) begin
            tx_outstanding = 1'b1;
            written        = 1'b1;
            add_cmd(CMD_WRITE);
         end
         if (!written) begin
            if (!st2[ST_TXFULL_BIT] && !st2[ST_MAXRT_BIT] && tx_outstanding) begin
               quiet_next = {1'b0, quiet_polls} + 9'd1;
               if (quiet_next > {1'b0, quiet_limit}) begin
                  quiet_polls    = 8'd0;
                  tx_outstanding = 1'b0;
                  link_down      = 1'b1;
                  led_on         = 1'b0;
               end else begin
                  quiet_polls = quiet_next[7:0];
               end
            end
            if (st2[ST_MAXRT_BIT]) begin
               led_on = 1'b0;
               if (retry_events < retry_cap) begin
                  retry_events = retry_events + 8'd1;
                  add_cmd(CMD_CLR_MAXRT);
               end else begin
                  retry_events = 8'd0;
                  link_down    = 1'b1;
                  add_cmd(CMD_FLUSH_TX);
               end
            end
         end
      end
      if (poll_len == 0) add_cmd(CMD_NONE);
      poll_cmds[poll_len-1].last = 1'b1;
      for (int i = 0; i < poll_len; i++) cmd_queue.push_back(poll_cmds[i]);
   endtask

   always @(posedge clock) begin
      bus_cmd_type want;
      if (reset) begin
         quiet_limit    = LIMIT_RESET;
         retry_cap      = LIMIT_RESET;
         link_down      = 1'b1;
         tx_outstanding = 1'b0;
         quiet_polls    = 8'd0;
         retry_events   = 8'd0;
         led_on         = 1'b0;
         cmd_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_SILENCE_LIMIT, 2'b00}) quiet_limit = csr_pwdata[7:0];
            else if (csr_paddr == {REG_RETRY_LIMIT, 2'b00}) retry_cap = csr_pwdata[7:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_queue.size() == 0) begin
               report_mismatch("unexpected command", rsp_tdata[2:0], -1);
            end else begin
               want = cmd_queue.pop_front();
               if (rsp_tdata[2:0] != want.cmd)
                  report_mismatch("command", rsp_tdata[2:0], want.cmd);
               if (rsp_tdata[3] != want.link_up)
                  report_mismatch("link_up", rsp_tdata[3], want.link_up);
               if (rsp_tdata[4] != want.led_state)
                  report_mismatch("led_state", rsp_tdata[4], want.led_state);
               if (rsp_tdata[7:5] != 3'd0)
                  report_mismatch("tdata pad", rsp_tdata[7:5], 0);
               if (rsp_tlast != want.last)
                  report_mismatch("tlast", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready)
            supervise_poll(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
      end
      outstanding = cmd_queue.size();
   end

endmodule

### tb/radio_tx_link_supervisor_test.sv
// top of the radio transmit link supervisor testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module radio_tx_link_supervisor_test;
   import rtls_pkg::*;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [23:0] req_tdata   = 24'd0;   // status_first, queue_status, status_second
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;             // command[2:0], link_up, led_state, zero pad
   logic        rsp_tlast;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int outstanding;
   bit calm     = 1'b0;
   bit hold_rsp = 1'b0;

   radio_tx_link_supervisor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   link_supervisor_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stalls, and one long hold-off on request
   initial begin
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_csr(input logic [2:0] addr, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_limits(input logic [7:0] quiet, input logic [7:0] retries);
      write_csr({REG_SILENCE_LIMIT, 2'b00}, quiet);
      write_csr({REG_RETRY_LIMIT, 2'b00}, retries);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_poll(input logic [7:0] st1, input logic [7:0] fifo,
                            input logic [7:0] st2);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {st2, fifo, st1};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // quiet polls keep the second status silent so a pending payload keeps counting
   task automatic send_random_polls(input int count, input bit quiet);
      logic [7:0] st1, fifo, st2;
      int pick;
      for (int i = 0; i < count; i++) begin
         st1  = 8'($urandom);
         fifo = 8'($urandom);
         st2  = 8'($urandom);
         pick = $urandom_range(0, 19);
         if (quiet) begin
            if (pick != 0) st2 &= ~8'h31;
            else st2 = (st2 | 8'h01) & ~8'h10;
         end else if (pick >= 4 && pick < 10) begin
            st2 &= ~8'h31;
         end else if (pick >= 10 && pick < 13) begin
            st2 = (st2 | 8'h20) & ~8'h11;
         end else if (pick >= 13 && pick < 16) begin
            st2 |= 8'h10;
         end else if (pick >= 16) begin
            st2 = (st2 | 8'h01) & ~8'h10;
         end
         send_poll(st1, fifo, st2);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed polls with both limits at one
      set_limits(8'd1, 8'd1);
      send_poll(8'h00, 8'h00, 8'h00);
      send_poll(8'h11, 8'h22, 8'hFF);
      send_poll(8'h00, 8'h20, 8'hFF);
      send_poll(8'h21, 8'h00, 8'h01);
      send_poll(8'hFF, 8'hFF, 8'h00);
      send_poll(8'h00, 8'h00, 8'h00);
      send_poll(8'h00, 8'h00, 8'h00);
      send_poll(8'h20, 8'h20, 8'h00);
      send_poll(8'h00, 8'h00, 8'h10);
      send_poll(8'h00, 8'h00, 8'h10);
      send_poll(8'h31, 8'h02, 8'h20);
      send_poll(8'h00, 8'h00, 8'h21);
      send_poll(8'hFF, 8'hFF, 8'hFF);
      send_poll(8'h00, 8'h00, 8'h31);
      send_poll(8'hFF, 8'hFF, 8'hFF);
      send_poll(8'h00, 8'h00, 8'h00);
      wait_for_results();

      set_limits(8'd0, 8'd0);
      send_random_polls(30, 1'b0);
      wait_for_results();

      // build up a silence count, then lower the limit under it
      set_limits(8'd30, 8'd30);
      send_poll(8'h20, 8'h20, 8'h00);
      send_random_polls(15, 1'b1);
      wait_for_results();
      set_limits(8'd2, 8'd255);
      send_random_polls(20, 1'b0);
      wait_for_results();

      set_limits(8'($urandom_range(1, 8)), 8'($urandom_range(0, 6)));
      hold_rsp = 1'b1;
      send_random_polls(35, 1'b0);
      wait_for_results();

      // wide silence limit: the count must run past it
      set_limits(8'd100, 8'd255);
      send_poll(8'h20, 8'h20, 8'h00);
      send_random_polls(115, 1'b1);
      wait_for_results();

      calm = 1'b1;
      set_limits(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
      send_random_polls(40, 1'b0);
      wait_for_results();
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
